FILE: hw/rtl/nbmu_pkg.sv
// ----------------------------------------------------------------------------
// Neuron backprop momentum unit package
// Shared types, codes and constants of the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package nbmu_pkg;

  // Number of incoming connections, one store entry each.
  localparam int unsigned MaxInputs = 256;

  // Fixed-point constants.
  localparam int unsigned OneQ14   = 16384;
  localparam int unsigned Tanh27   = 27 << 16;
  localparam int unsigned TanhLim  = 3 << 16;

  // Restoring divider of the tanh approximation: one quotient bit a cycle.
  localparam int unsigned DivSteps = 16;
  localparam int unsigned DivCntW  = 4;

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_FWD    = 3'd1,
    OP_OGRAD  = 3'd2,
    OP_HGRAD  = 3'd3,
    OP_UPDATE = 3'd4
  } op_e;

  localparam logic [1:0] KIND_OUT    = 2'd0;
  localparam logic [1:0] KIND_GRAD   = 2'd1;
  localparam logic [1:0] KIND_WEIGHT = 2'd2;

  localparam logic [0:0] CFG_LEARN_RATE = 1'b0;
  localparam logic [0:0] CFG_MOMENTUM   = 1'b1;

  localparam logic [15:0] LearnRateRst = 16'd9830;
  localparam logic [15:0] MomentumRst  = 16'd32768;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_READ,
    ST_MAC_MUL,
    ST_MAC_ACC,
    ST_TANH_SQ,
    ST_TANH_NUM,
    ST_TANH_DIV,
    ST_TANH_END,
    ST_SLOPE,
    ST_GRAD_MUL,
    ST_GRAD_END,
    ST_UPD_MUL1,
    ST_UPD_MUL2,
    ST_UPD_MUL3,
    ST_UPD_END
  } state_e;

  typedef enum logic [4:0] {
    UOP_NONE,
    UOP_CAPTURE,
    UOP_LOAD,
    UOP_READ,
    UOP_MAC_MUL,
    UOP_MAC_ACC,
    UOP_TANH_SQ,
    UOP_TANH_NUM,
    UOP_DIV_STEP,
    UOP_TANH_END,
    UOP_SLOPE,
    UOP_GRAD_MUL,
    UOP_GRAD_END,
    UOP_UPD_MUL1,
    UOP_UPD_MUL2,
    UOP_UPD_MUL3,
    UOP_UPD_END
  } uop_e;

  typedef struct packed {
    uop_e uop;
    logic div_first;
    logic hidden;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/nbmu_ctrl.sv
// ----------------------------------------------------------------------------
// Neuron backprop momentum unit controller
// Sequences one request at a time through the datapath micro-operations.
// ----------------------------------------------------------------------------
`default_nettype none

module nbmu_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic [2:0]    opcode_i,
  input  logic          last_i,
  output logic          busy,
  output nbmu_pkg::cmd_t cmd_o
);
  import nbmu_pkg::*;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   last_q, last_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_LOAD;
      last_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      last_q  <= last_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    last_d  = last_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          op_d   = op_e'(opcode_i);
          last_d = last_i;
          case (opcode_i)
            OP_LOAD:   state_d = ST_LOAD;
            OP_FWD:    state_d = ST_READ;
            OP_OGRAD:  state_d = ST_SLOPE;
            OP_HGRAD:  state_d = ST_MAC_MUL;
            OP_UPDATE: state_d = ST_READ;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOAD:     state_d = ST_IDLE;
      ST_READ:     state_d = (op_q == OP_FWD) ? ST_MAC_MUL : ST_UPD_MUL1;
      ST_MAC_MUL:  state_d = ST_MAC_ACC;
      ST_MAC_ACC: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (op_q == OP_FWD) begin
          state_d = ST_TANH_SQ;
        end else begin
          state_d = ST_SLOPE;
        end
      end
      ST_TANH_SQ:  state_d = ST_TANH_NUM;
      ST_TANH_NUM: begin
        state_d = ST_TANH_DIV;
        cnt_d   = DivCntW'(DivSteps - 1);
      end
      ST_TANH_DIV: begin
        if (cnt_q == '0) begin
          state_d = ST_TANH_END;
        end else begin
          cnt_d = cnt_q - DivCntW'(1);
        end
      end
      ST_TANH_END: state_d = ST_IDLE;
      ST_SLOPE:    state_d = ST_GRAD_MUL;
      ST_GRAD_MUL: state_d = ST_GRAD_END;
      ST_GRAD_END: state_d = ST_IDLE;
      ST_UPD_MUL1: state_d = ST_UPD_MUL2;
      ST_UPD_MUL2: state_d = ST_UPD_MUL3;
      ST_UPD_MUL3: state_d = ST_UPD_END;
      ST_UPD_END:  state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    busy             = (state_q != ST_IDLE);
    cmd_o.hidden     = (op_q == OP_HGRAD);
    cmd_o.div_first  = (cnt_q == DivCntW'(DivSteps - 1));
    cmd_o.uop        = UOP_NONE;
    unique case (state_q)
      ST_IDLE:     cmd_o.uop = start ? UOP_CAPTURE : UOP_NONE;
      ST_LOAD:     cmd_o.uop = UOP_LOAD;
      ST_READ:     cmd_o.uop = UOP_READ;
      ST_MAC_MUL:  cmd_o.uop = UOP_MAC_MUL;
      ST_MAC_ACC:  cmd_o.uop = UOP_MAC_ACC;
      ST_TANH_SQ:  cmd_o.uop = UOP_TANH_SQ;
      ST_TANH_NUM: cmd_o.uop = UOP_TANH_NUM;
      ST_TANH_DIV: cmd_o.uop = UOP_DIV_STEP;
      ST_TANH_END: cmd_o.uop = UOP_TANH_END;
      ST_SLOPE:    cmd_o.uop = UOP_SLOPE;
      ST_GRAD_MUL: cmd_o.uop = UOP_GRAD_MUL;
      ST_GRAD_END: cmd_o.uop = UOP_GRAD_END;
      ST_UPD_MUL1: cmd_o.uop = UOP_UPD_MUL1;
      ST_UPD_MUL2: cmd_o.uop = UOP_UPD_MUL2;
      ST_UPD_MUL3: cmd_o.uop = UOP_UPD_MUL3;
      ST_UPD_END:  cmd_o.uop = UOP_UPD_END;
      default:     cmd_o.uop = UOP_NONE;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/nbmu_dp.sv
// ----------------------------------------------------------------------------
// Neuron backprop momentum unit datapath
// Weight and momentum stores, one shared multiplier, accumulator and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module nbmu_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nbmu_pkg::cmd_t      cmd_i,
  input  logic [7:0]          index_i,
  input  logic signed [15:0]  activation_i,
  input  logic signed [15:0]  target_i,
  input  logic signed [23:0]  weight_in_i,
  input  logic signed [23:0]  next_gradient_i,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_index_i,
  input  logic [15:0]         cfg_wdata_i,
  output logic                result_valid_o,
  output logic [1:0]          result_kind_o,
  output logic signed [23:0]  result_value_o
);
  import nbmu_pkg::*;

  function automatic logic signed [23:0] sat24(input logic signed [65:0] v);
    logic signed [23:0] r;
    if (v > 66'sd8388607) begin
      r = 24'sd8388607;
    end else if (v < -66'sd8388608) begin
      r = -24'sd8388608;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // Captured request fields.
  logic [7:0]         idx_q;
  logic signed [15:0] act_q, tgt_q;
  logic signed [23:0] win_q, ng_q;

  // Stores and their registered read data.
  logic [23:0] wmem [MaxInputs];
  logic [23:0] mmem [MaxInputs];
  logic signed [23:0] wrd_q, mrd_q;

  // Configuration.
  logic [15:0] lr_q, mom_q;

  // Arithmetic state.
  logic signed [39:0] acc_q;
  logic signed [15:0] out_q;
  logic signed [23:0] grad_q;
  logic signed [65:0] prod_q;
  logic [17:0]        abs_q;
  logic               neg_q, sat_q;
  logic [24:0]        den_q;
  logic [39:0]        rem_q, dvs_q;
  logic [15:0]        quo_q;
  logic signed [26:0] p1_q;

  logic               res_valid_q;
  logic [1:0]         res_kind_q;
  logic signed [23:0] res_value_q;

  // Combinational terms.
  logic signed [40:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [65:0] mul_p;
  logic signed [17:0] slope_d;
  logic signed [65:0] mac_sh;
  logic signed [41:0] acc_sum;
  logic signed [39:0] acc_sat;
  logic signed [39:0] acc_abs;
  logic [19:0]        x2;
  logic [39:0]        rem_in, dvs_in;
  logic               div_ge;
  logic signed [15:0] tanh_y;
  logic signed [65:0] grad_sh;
  logic signed [27:0] delta_sum;
  logic signed [23:0] delta;
  logic signed [24:0] w_sum;
  logic signed [23:0] w_new;

  assign slope_d = 18'sd16384 - $signed({1'b0, prod_q[30:14]});
  assign mac_sh  = cmd_i.hidden ? (prod_q >>> 16) : (prod_q >>> 14);
  assign acc_sum = 42'(acc_q) + mac_sh[41:0];
  assign acc_abs = acc_q[39] ? -acc_q : acc_q;
  assign x2      = prod_q[35:16];

  always_comb begin
    if (acc_sum[41:39] == 3'b000 || acc_sum[41:39] == 3'b111) begin
      acc_sat = acc_sum[39:0];
    end else if (acc_sum[41]) begin
      acc_sat = {1'b1, 39'd0};
    end else begin
      acc_sat = {1'b0, {39{1'b1}}};
    end
  end

  // Shared multiplier; operands selected by the current micro-operation.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.uop)
      UOP_MAC_MUL: begin
        if (cmd_i.hidden) begin
          mul_a = 41'(win_q);
          mul_b = 25'(ng_q);
        end else begin
          mul_a = 41'(act_q);
          mul_b = 25'(wrd_q);
        end
      end
      UOP_TANH_SQ: begin
        mul_a = $signed({23'd0, acc_abs[17:0]});
        mul_b = $signed({7'd0, acc_abs[17:0]});
      end
      UOP_TANH_NUM: begin
        mul_a = $signed({23'd0, abs_q});
        mul_b = $signed(25'(Tanh27) + {5'd0, x2});
      end
      UOP_SLOPE: begin
        mul_a = 41'(out_q);
        mul_b = 25'(out_q);
      end
      UOP_GRAD_MUL: begin
        mul_a = cmd_i.hidden ? 41'(acc_q) : 41'(17'(tgt_q) - 17'(out_q));
        mul_b = 25'(slope_d);
      end
      UOP_UPD_MUL1: begin
        mul_a = 41'(act_q);
        mul_b = 25'(grad_q);
      end
      UOP_UPD_MUL2: begin
        mul_a = prod_q[40:0];
        mul_b = $signed({9'd0, lr_q});
      end
      UOP_UPD_MUL3: begin
        mul_a = 41'(mrd_q);
        mul_b = $signed({9'd0, mom_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 66'(mul_a) * 66'(mul_b);

  // Divider step: trial divisor starts at den << 15 and halves each cycle.
  assign rem_in = cmd_i.div_first ? prod_q[39:0] : rem_q;
  assign dvs_in = cmd_i.div_first ? {den_q, 15'd0} : dvs_q;
  assign div_ge = (rem_in >= dvs_in);

  always_comb begin
    if (sat_q) begin
      tanh_y = neg_q ? -16'sd16384 : 16'sd16384;
    end else begin
      tanh_y = neg_q ? -$signed(quo_q) : $signed(quo_q);
    end
  end

  assign grad_sh   = cmd_i.hidden ? (prod_q >>> 14) : (prod_q >>> 12);
  assign delta_sum = 28'(p1_q) + 28'(prod_q >>> 16);
  assign delta     = sat24(66'(delta_sum));
  assign w_sum     = 25'(wrd_q) + 25'(delta);
  assign w_new     = sat24(66'(w_sum));

  // Request capture and stores.
  always_ff @(posedge clk_i) begin
    if (cmd_i.uop == UOP_CAPTURE) begin
      idx_q <= index_i;
      act_q <= activation_i;
      tgt_q <= target_i;
      win_q <= weight_in_i;
      ng_q  <= next_gradient_i;
    end
    if (cmd_i.uop == UOP_READ) begin
      wrd_q <= wmem[idx_q];
      mrd_q <= mmem[idx_q];
    end
    if (cmd_i.uop == UOP_LOAD) begin
      wmem[idx_q] <= win_q;
      mmem[idx_q] <= '0;
    end else if (cmd_i.uop == UOP_UPD_END) begin
      wmem[idx_q] <= w_new;
      mmem[idx_q] <= delta;
    end
  end

  // Working registers without reset.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (cmd_i.uop == UOP_TANH_SQ) begin
      abs_q <= acc_abs[17:0];
    end
    if (cmd_i.uop == UOP_TANH_NUM) begin
      den_q <= 25'({3'd0, 22'(Tanh27)} + {2'd0, x2, 3'd0} + {5'd0, x2}) << 2;
    end
    if (cmd_i.uop == UOP_DIV_STEP) begin
      rem_q <= div_ge ? (rem_in - dvs_in) : rem_in;
      dvs_q <= dvs_in >> 1;
      quo_q <= cmd_i.div_first ? {15'd0, div_ge} : {quo_q[14:0], div_ge};
    end
    if (cmd_i.uop == UOP_UPD_MUL3) begin
      p1_q <= 27'(prod_q >>> 30);
    end
    case (cmd_i.uop)
      UOP_GRAD_END: begin
        res_kind_q  <= KIND_GRAD;
        res_value_q <= sat24(grad_sh);
      end
      UOP_UPD_END: begin
        res_kind_q  <= KIND_WEIGHT;
        res_value_q <= w_new;
      end
      default: begin
        res_kind_q  <= KIND_OUT;
        res_value_q <= 24'(tanh_y);
      end
    endcase
  end

  // Architectural state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_q       <= '0;
      grad_q      <= '0;
      neg_q       <= 1'b0;
      sat_q       <= 1'b0;
      lr_q        <= LearnRateRst;
      mom_q       <= MomentumRst;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_LEARN_RATE) begin
          lr_q <= cfg_wdata_i;
        end else if (cfg_index_i == CFG_MOMENTUM) begin
          mom_q <= cfg_wdata_i;
        end
      end
      case (cmd_i.uop)
        UOP_MAC_ACC: acc_q <= acc_sat;
        UOP_TANH_SQ: begin
          neg_q <= acc_q[39];
          sat_q <= (acc_q >= 40'sd196608) || (acc_q <= -40'sd196608);
        end
        UOP_TANH_END: begin
          out_q <= tanh_y;
          acc_q <= '0;
        end
        UOP_GRAD_END: begin
          grad_q <= sat24(grad_sh);
          if (cmd_i.hidden) begin
            acc_q <= '0;
          end
        end
        default: ;
      endcase
      res_valid_q <= (cmd_i.uop == UOP_TANH_END) || (cmd_i.uop == UOP_GRAD_END) ||
                     (cmd_i.uop == UOP_UPD_END);
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_kind_o  = res_kind_q;
  assign result_value_o = res_value_q;

endmodule

`default_nettype wire

FILE: hw/rtl/neuron_backprop_momentum_unit.sv
// ----------------------------------------------------------------------------
// Neuron backprop momentum unit
// One tanh neuron with weight and momentum stores, trained by SGD with momentum.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; the unit works on one
// request at a time and raises busy until it is done. A load writes the stores;
// a forward term accumulates a product and, when it closes the sum, also runs
// the tanh divide, one quotient bit a cycle; an output gradient multiplies by
// the slope; a hidden gradient term accumulates a product and, when it closes
// the sum, forms the gradient; an update reads the stores and multiplies. The
// pace is set by the single shared multiplier, which each product passes
// through with a register after it, and by the serial divider. A result is on
// the result ports, with result_valid_o high, for exactly one cycle, the first
// one with busy low again; the receiver cannot hold it off, so it must take it
// then. Configuration writes are applied at once and are meant for idle time.
`default_nettype none

module neuron_backprop_momentum_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         opcode_i,
  input  logic [7:0]         index_i,
  input  logic signed [15:0] activation_i,
  input  logic signed [15:0] target_i,
  input  logic signed [23:0] weight_in_i,
  input  logic signed [23:0] next_gradient_i,
  input  logic               last_i,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_index_i,
  input  logic [15:0]        cfg_wdata_i,
  output logic               result_valid_o,
  output logic [1:0]         result_kind_o,
  output logic signed [23:0] result_value_o
);
  import nbmu_pkg::*;

  // Command bundle from the sequencer to the datapath.
  cmd_t cmd;

  nbmu_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (opcode_i),
    .last_i   (last_i),
    .busy     (busy),
    .cmd_o    (cmd)
  );

  // The datapath holds both stores, the accumulator and the result register.
  nbmu_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .index_i         (index_i),
    .activation_i    (activation_i),
    .target_i        (target_i),
    .weight_in_i     (weight_in_i),
    .next_gradient_i (next_gradient_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .result_valid_o  (result_valid_o),
    .result_kind_o   (result_kind_o),
    .result_value_o  (result_value_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/nbmu_checker.sv
// ----------------------------------------------------------------------------
// Neuron backprop momentum unit checker
// Port-level checks on request and result timing and result values, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nbmu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [2:0]  opcode_i,
  input logic        result_valid_o,
  input logic [1:0]  result_kind_o,
  input logic [23:0] result_value_o
);
  import nbmu_pkg::*;

  // A taken request never produces a result in the very next cycle.
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !result_valid_o)
    else $error("result too soon after a request");

  // A request with a defined opcode keeps the unit busy afterwards.
  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (opcode_i == OP_LOAD || opcode_i == OP_FWD ||
     opcode_i == OP_OGRAD || opcode_i == OP_HGRAD || opcode_i == OP_UPDATE)) |=> busy)
    else $error("busy not raised after a request");

  // Results are single-cycle strobes shown while idle.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (!busy ##1 !result_valid_o))
    else $error("result strobe longer than one cycle or while busy");

  // Output values are within plus or minus one in Q2.14.
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_kind_o == KIND_OUT) |->
      ($signed(result_value_o) <= 24'sd16384 && $signed(result_value_o) >= -24'sd16384))
    else $error("output value out of range");

  a_kind_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_kind_o == KIND_OUT || result_kind_o == KIND_GRAD ||
                        result_kind_o == KIND_WEIGHT))
    else $error("undefined result kind");

endmodule

bind neuron_backprop_momentum_unit nbmu_checker u_nbmu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .opcode_i       (opcode_i),
  .result_valid_o (result_valid_o),
  .result_kind_o  (result_kind_o),
  .result_value_o (result_value_o)
);

`default_nettype wire

FILE: test/neuron_backprop_momentum_unit_test.sv
// ----------------------------------------------------------------------------
// Neuron backprop momentum unit testbench
// Drives load, forward, gradient and update requests and checks each result
// against an in-bench fixed-point model of the neuron.
// ----------------------------------------------------------------------------
module neuron_backprop_momentum_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import nbmu_pkg::*;

  // Opcodes that the unit does not implement. It must ignore them.
  localparam logic [2:0] OpUnusedFirst = 3'd5;
  localparam logic [2:0] OpUnusedMid   = 3'd6;
  localparam logic [2:0] OpUnusedLast  = 3'd7;
  // The longest request is a forward term that closes the sum.
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned WatchdogLimit = 2000;

  localparam longint AccMax = 64'sd549755813887;
  localparam longint AccMin = -AccMax - 1;
  localparam longint V24Max = 64'sd8388607;
  localparam longint V24Min = -64'sd8388608;

  typedef struct {
    logic [1:0]  kind;
    logic [23:0] value;
  } neuron_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [2:0]         opcode_i;
  logic [7:0]         index_i;
  logic signed [15:0] activation_i;
  logic signed [15:0] target_i;
  logic signed [23:0] weight_in_i;
  logic signed [23:0] next_gradient_i;
  logic               last_i;
  logic               cfg_we_i;
  logic [0:0]         cfg_index_i;
  logic [15:0]        cfg_wdata_i;
  logic               result_valid_o;
  logic [1:0]         result_kind_o;
  logic signed [23:0] result_value_o;

  neuron_backprop_momentum_unit u_dut (.*);

  // Model state of the neuron, updated as each request is taken.
  longint weight_mem [MaxInputs];
  longint momentum_mem [MaxInputs];
  bit     weight_written [MaxInputs];
  int     written_list [$];
  longint sum_acc;
  longint neuron_out;
  longint neuron_grad;
  longint rate_q16;
  longint alpha_q16;

  neuron_result_t pending_results [$];
  int     error_count;
  int     quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Slope of tanh at the current output: 1 - out^2 in Q2.14.
  function automatic longint tanh_slope();
    return longint'(OneQ14) - ((neuron_out * neuron_out) >>> 14);
  endfunction

  // Rational tanh approximation; the magnitude is divided, then the sign put back.
  function automatic longint tanh_approx(longint x);
    longint mag, sq, num, den, q;
    if (x >= (longint'(3) <<< 16)) return longint'(OneQ14);
    if (x <= -(longint'(3) <<< 16)) return -longint'(OneQ14);
    mag = x < 0 ? -x : x;
    sq  = (mag * mag) >>> 16;
    num = mag * ((longint'(27) <<< 16) + sq);
    den = ((longint'(27) <<< 16) + 9 * sq) * 4;
    q   = num / den;
    return x < 0 ? -q : q;
  endfunction

  // Advances the model by one taken request and queues the result it causes.
  task automatic predict_neuron(logic [2:0] op, logic [7:0] idx, logic signed [15:0] act,
                                logic signed [15:0] tgt, logic signed [23:0] win,
                                logic signed [23:0] ng, logic lst);
    longint a, t, w, n, delta;
    neuron_result_t res;
    a = act;
    t = tgt;
    w = win;
    n = ng;
    case (op)
      OP_LOAD: begin
        weight_mem[idx]   = w;
        momentum_mem[idx] = 0;
        if (!weight_written[idx]) written_list = {written_list, int'(idx)};
        weight_written[idx] = 1'b1;
      end
      OP_FWD: begin
        sum_acc = clamp(sum_acc + ((a * weight_mem[idx]) >>> 14), AccMin, AccMax);
        if (lst) begin
          neuron_out = tanh_approx(sum_acc);
          sum_acc = 0;
          res.kind = KIND_OUT;
          res.value = neuron_out[23:0];
          pending_results = {pending_results, res};
        end
      end
      OP_OGRAD: begin
        neuron_grad = clamp(((t - neuron_out) * tanh_slope()) >>> 12, V24Min, V24Max);
        res.kind = KIND_GRAD;
        res.value = neuron_grad[23:0];
        pending_results = {pending_results, res};
      end
      OP_HGRAD: begin
        sum_acc = clamp(sum_acc + ((w * n) >>> 16), AccMin, AccMax);
        if (lst) begin
          neuron_grad = clamp((sum_acc * tanh_slope()) >>> 14, V24Min, V24Max);
          sum_acc = 0;
          res.kind = KIND_GRAD;
          res.value = neuron_grad[23:0];
          pending_results = {pending_results, res};
        end
      end
      OP_UPDATE: begin
        delta = ((rate_q16 * (a * neuron_grad)) >>> 30)
              + ((alpha_q16 * momentum_mem[idx]) >>> 16);
        delta = clamp(delta, V24Min, V24Max);
        momentum_mem[idx] = delta;
        weight_mem[idx] = clamp(weight_mem[idx] + delta, V24Min, V24Max);
        res.kind = KIND_WEIGHT;
        res.value = weight_mem[idx][23:0];
        pending_results = {pending_results, res};
      end
      default: ;
    endcase
  endtask

  // Results are strobed for one cycle; each one is matched with the oldest
  // expectation at the rising edge that ends its cycle.
  always @(posedge clk_i) begin
    neuron_result_t exp_res;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind %0d value %0d", $time,
                 result_kind_o, result_value_o);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (result_kind_o !== exp_res.kind) begin
          $display("%0t: result_kind expected %0d actual %0d", $time,
                   exp_res.kind, result_kind_o);
          error_count++;
        end
        if (result_value_o !== exp_res.value) begin
          $display("%0t: result_value expected %0d actual %0d", $time,
                   $signed(exp_res.value), result_value_o);
          error_count++;
        end
      end
    end
  end

  // The watchdog ends a run in which neither a request nor a result moves.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Holds start low for a random stretch, as often as idle_pct says.
  task automatic sender_gap(int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
  endtask

  // Presents one request at the falling edge and waits until it is taken.
  // Start stays high afterwards so that back-to-back requests leave no gap.
  task automatic send_request(logic [2:0] op, logic [7:0] idx, logic signed [15:0] act,
                              logic signed [15:0] tgt, logic signed [23:0] win,
                              logic signed [23:0] ng, logic lst);
    start = 1'b1;
    opcode_i = op;
    index_i = idx;
    activation_i = act;
    target_i = tgt;
    weight_in_i = win;
    next_gradient_i = ng;
    last_i = lst;
    do @(posedge clk_i); while (busy);
    predict_neuron(op, idx, act, tgt, win, ng, lst);
    @(negedge clk_i);
  endtask

  // Lets the unit go idle: every result in, then enough cycles for a request
  // that produces nothing to finish.
  task automatic drain();
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_config(logic [0:0] reg_idx, logic [15:0] value);
    cfg_we_i = 1'b1;
    cfg_index_i = reg_idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (reg_idx == CFG_LEARN_RATE) rate_q16 = value;
    else alpha_q16 = value;
  endtask

  // Mostly small values so that sums stay in range, sometimes anything.
  function automatic logic signed [15:0] pick_q14();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic signed [23:0] pick_q16();
    if ($urandom_range(0, 3) == 0) return 24'($urandom);
    return 24'($signed($urandom_range(0, 262144)) - 131072);
  endfunction

  // Index of a weight that has been loaded, so no unwritten entry is read.
  function automatic logic [7:0] pick_loaded();
    return 8'(written_list[$urandom_range(0, written_list.size() - 1)]);
  endfunction

  task automatic test_directed();
    // Extremes of the stored weight at both ends of the index range.
    send_request(OP_LOAD, 8'd0, 16'sd0, 16'sd0, 24'sh7FFFFF, 24'sd0, 1'b0);
    send_request(OP_LOAD, 8'd255, 16'sd0, 16'sd0, 24'sh800000, 24'sd0, 1'b0);
    send_request(OP_LOAD, 8'd170, 16'sd0, 16'sd0, 24'sd65536, 24'sd0, 1'b0);
    // A forward sum that drives tanh into positive, then negative saturation.
    send_request(OP_FWD, 8'd0, 16'sh7FFF, 16'sd0, 24'sd0, 24'sd0, 1'b1);
    send_request(OP_FWD, 8'd255, 16'sh7FFF, 16'sd0, 24'sd0, 24'sd0, 1'b1);
    // A small sum inside the rational region of the approximation.
    send_request(OP_FWD, 8'd170, 16'sd8192, 16'sd0, 24'sd0, 24'sd0, 1'b0);
    send_request(OP_FWD, 8'd170, -16'sd4000, 16'sd0, 24'sd0, 24'sd0, 1'b1);
    send_request(OP_OGRAD, 8'd0, 16'sd0, 16'sh7FFF, 24'sd0, 24'sd0, 1'b0);
    send_request(OP_OGRAD, 8'd0, 16'sd0, 16'sh8000, 24'sd0, 24'sd0, 1'b0);
    // Hidden gradient with extreme products of weight and next gradient.
    send_request(OP_HGRAD, 8'd0, 16'sd0, 16'sd0, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
    send_request(OP_HGRAD, 8'd0, 16'sd0, 16'sd0, 24'sh800000, 24'sh7FFFFF, 1'b1);
    send_request(OP_HGRAD, 8'd0, 16'sd0, 16'sd0, 24'sh800000, 24'sh800000, 1'b1);
    // Updates that saturate the weight, then reuse momentum.
    send_request(OP_UPDATE, 8'd0, 16'sh7FFF, 16'sd0, 24'sd0, 24'sd0, 1'b0);
    send_request(OP_UPDATE, 8'd0, 16'sh8000, 16'sd0, 24'sd0, 24'sd0, 1'b0);
    send_request(OP_UPDATE, 8'd255, 16'sh8000, 16'sd0, 24'sd0, 24'sd0, 1'b0);
    // Unused opcodes are ignored, even with last set.
    send_request(OpUnusedFirst, 8'd0, 16'sd1, 16'sd1, 24'sd1, 24'sd1, 1'b1);
    send_request(OpUnusedMid, 8'd255, 16'sh8000, 16'sh7FFF, 24'sd1, 24'sd1, 1'b1);
    send_request(OpUnusedLast, 8'd1, 16'sd0, 16'sd0, 24'sd0, 24'sd0, 1'b0);
    // An open forward sum is closed by a hidden term that carries last.
    send_request(OP_FWD, 8'd170, 16'sd16384, 16'sd0, 24'sd0, 24'sd0, 1'b0);
    send_request(OP_HGRAD, 8'd0, 16'sd0, 16'sd0, 24'sd65536, 24'sd65536, 1'b1);
    drain();
  endtask

  // Well-formed training passes with random content, plus stray requests.
  task automatic test_random(int count, int idle_pct);
    int sent, terms, i;
    logic [7:0] conn [$];
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        sender_gap(idle_pct);
        if ($urandom_range(0, 4) == 0) begin
          send_request(3'($urandom_range(OpUnusedFirst, OpUnusedLast)), 8'($urandom),
                       16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom),
                       1'($urandom));
        end else begin
          send_request(3'($urandom_range(OP_FWD, OP_UPDATE)), pick_loaded(), pick_q14(),
                       pick_q14(), pick_q16(), pick_q16(), 1'($urandom));
          sent++;
        end
        continue;
      end
      terms = $urandom_range(1, 6);
      conn.delete();
      for (i = 0; i < terms; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          conn = {conn, 8'($urandom)};
          sender_gap(idle_pct);
          send_request(OP_LOAD, conn[i], pick_q14(), pick_q14(), pick_q16(),
                       pick_q16(), 1'($urandom));
          sent++;
        end else begin
          conn = {conn, pick_loaded()};
        end
      end
      for (i = 0; i < terms; i++) begin
        sender_gap(idle_pct);
        send_request(OP_FWD, conn[i], pick_q14(), pick_q14(), pick_q16(), pick_q16(),
                     i == terms - 1);
        sent++;
      end
      if ($urandom_range(0, 1) == 0) begin
        sender_gap(idle_pct);
        send_request(OP_OGRAD, 8'($urandom), pick_q14(), pick_q14(), pick_q16(),
                     pick_q16(), 1'($urandom));
        sent++;
      end else begin
        for (i = $urandom_range(1, 4); i > 0; i--) begin
          sender_gap(idle_pct);
          send_request(OP_HGRAD, 8'($urandom), pick_q14(), pick_q14(), pick_q16(),
                       pick_q16(), i == 1);
          sent++;
        end
      end
      for (i = 0; i < terms; i++) begin
        sender_gap(idle_pct);
        send_request(OP_UPDATE, conn[i], pick_q14(), pick_q14(), pick_q16(), pick_q16(),
                     1'($urandom));
        sent++;
      end
    end
    drain();
  endtask

  initial begin
    error_count = 0;
    quiet_cycles = 0;
    sum_acc = 0;
    neuron_out = 0;
    neuron_grad = 0;
    rate_q16 = LearnRateRst;
    alpha_q16 = MomentumRst;
    rst_ni = 1'b0;
    start = 1'b0;
    opcode_i = OP_LOAD;
    index_i = '0;
    activation_i = '0;
    target_i = '0;
    weight_in_i = '0;
    next_gradient_i = '0;
    last_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_LEARN_RATE;
    cfg_wdata_i = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset values of the rates first, then the extremes of both registers, then random values.
    test_directed();
    write_config(CFG_LEARN_RATE, 16'hFFFF);
    write_config(CFG_MOMENTUM, 16'h0000);
    test_random(600, 31);
    write_config(CFG_LEARN_RATE, 16'h0000);
    write_config(CFG_MOMENTUM, 16'hFFFF);
    test_random(600, 81);
    write_config(CFG_LEARN_RATE, 16'($urandom));
    write_config(CFG_MOMENTUM, 16'($urandom));
    test_random(600, 0);

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
